// ===== sv/sitda_pkg.sv =====
// Shared types and constants for the signed integer to decimal ASCII core.
package sitda_pkg;

   localparam int NumberWidth   = 32;
   localparam int CharWidth     = 8;
   localparam int DigitWidth    = 4;
   localparam int NumDigits     = 10;
   localparam int BcdWidth      = NumDigits * DigitWidth;
   localparam int ShiftCntWidth = 5;
   localparam int DigitCntWidth = 4;

   localparam logic [CharWidth-1:0]     CharZero   = 8'h30;
   localparam logic [CharWidth-1:0]     CharMinus  = 8'h2D;
   localparam logic [DigitWidth-1:0]    DabbleMin  = 4'd5;
   localparam logic [DigitWidth-1:0]    DabbleAdd  = 4'd3;
   localparam logic [DigitWidth-1:0]    DigitMax   = 4'd9;
   localparam logic [ShiftCntWidth-1:0] LastShift  = 5'd31;
   localparam logic [DigitCntWidth-1:0] DigitsFull = 4'd10;
   localparam logic [DigitCntWidth-1:0] DigitsOne  = 4'd1;

   typedef logic [NumberWidth-1:0]             mag_type;
   typedef logic [DigitWidth-1:0]              digit_type;
   typedef logic [NumDigits-1:0][DigitWidth-1:0] bcd_type;

endpackage

// ===== sv/sitda_if.sv =====
// Valid/ready channel interfaces for request and response transactions.
interface sitda_req_if;
   import sitda_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [NumberWidth-1:0] number_in;
   modport source (output valid, output number_in, input ready);
   modport sink   (input valid, input number_in, output ready);
endinterface

interface sitda_rsp_if;
   import sitda_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CharWidth-1:0] ascii_char;
   logic                 run_last;
   modport source (output valid, output ascii_char, output run_last, input ready);
   modport sink   (input valid, input ascii_char, input run_last, output ready);
endinterface

// ===== sv/sitda_bcd_conv.sv =====
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
module sitda_bcd_conv (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  sitda_pkg::mag_type mag,
   output logic              done,
   output sitda_pkg::bcd_type bcd
);
   import sitda_pkg::*;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [ShiftCntWidth-1:0] cnt_ff, cnt_in;
   mag_type                  mag_ff, mag_in;
   bcd_type                  bcd_ff, bcd_in;
   bcd_type                  corr;
   logic [BcdWidth-1:0]      corr_flat;

   // Add 3 to every digit of 5 or more ahead of the shift.
   always_comb begin
      for (int i = 0; i < NumDigits; i++) begin
         corr[i] = (bcd_ff[i] >= DabbleMin) ? bcd_ff[i] + DabbleAdd : bcd_ff[i];
      end
   end

   assign corr_flat = corr;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      bcd_in  = bcd_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         mag_in  = mag;
         bcd_in  = '0;
      end else if (busy_ff) begin
         bcd_in = bcd_type'({corr_flat[BcdWidth-2:0], mag_ff[NumberWidth-1]});
         mag_in = {mag_ff[NumberWidth-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LastShift) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

// ===== sv/signed_int_to_decimal_ascii_core.sv =====
// Top level: signed 32-bit integer to decimal ASCII character stream.
//
// Each request transaction carries one signed 32-bit number; the core answers
// with its decimal text as a run of response transactions, one ASCII
// character each, most significant digit first, '-' ahead of a negative
// value, run_last set on the final character. Zero gives the single
// character '0', and the most negative value gives "-2147483648". One number
// is handled at a time: the request side is ready only between runs. A
// number passes through an accept step, the bit-serial BCD converter (one
// magnitude bit per cycle), a hand-off of the digits, a sign step when
// negative, a trim step that drops leading zeros but keeps the units digit,
// and an emit step that sends the characters as the response side takes
// them. The final character sits in the output register while the next
// request is taken.
module signed_int_to_decimal_ascii_core (
   input  logic        clock,
   input  logic        reset,
   sitda_req_if.sink   req_ch,
   sitda_rsp_if.source rsp_ch
);
   import sitda_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_TRIM,
      ST_EMIT
   } state_type;

   state_type                state_ff, state_in;
   logic                     neg_ff, neg_in;
   bcd_type                  bcd_ff, bcd_in;
   logic [DigitCntWidth-1:0] cnt_ff, cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CharWidth-1:0]     char_ff, char_in;
   logic                     last_ff, last_in;

   logic      req_accept;
   logic      out_free;
   logic      conv_done;
   bcd_type   conv_bcd;
   mag_type   raw;
   mag_type   mag;
   digit_type top_digit;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;

   // Form the magnitude as unsigned so the most negative value survives.
   assign raw = mag_type'(req_ch.number_in);
   assign mag = raw[NumberWidth-1] ? mag_type'(0) - raw : raw;

   sitda_bcd_conv u_conv (
      .clock (clock),
      .reset (reset),
      .start (req_accept),
      .mag   (mag),
      .done  (conv_done),
      .bcd   (conv_bcd)
   );

   assign top_digit = bcd_ff[NumDigits-1];

   // The output register can take a new character when empty or draining.
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      char_in      = char_ff;
      last_in      = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               neg_in   = req_ch.number_in[NumberWidth-1];
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            // Capture the digits once the converter finishes its shifts.
            if (conv_done) begin
               bcd_in   = conv_bcd;
               cnt_in   = DigitsFull;
               state_in = neg_ff ? ST_SIGN : ST_TRIM;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = CharMinus;
               last_in      = 1'b0;
               state_in     = ST_TRIM;
            end
         end
         ST_TRIM: begin
            // Drop leading zeros, but always keep the units digit.
            if (top_digit == '0 && cnt_ff != DigitsOne) begin
               bcd_in = bcd_type'({bcd_ff[NumDigits-2:0], digit_type'(0)});
               cnt_in = cnt_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = CharZero + {{(CharWidth-DigitWidth){1'b0}}, top_digit};
               last_in      = (cnt_ff == DigitsOne);
               bcd_in       = bcd_type'({bcd_ff[NumDigits-2:0], digit_type'(0)});
               cnt_in       = cnt_ff - 1'b1;
               if (cnt_ff == DigitsOne) begin
                  state_in = ST_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff  <= neg_in;
      bcd_ff  <= bcd_in;
      cnt_ff  <= cnt_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.ascii_char = char_ff;
   assign rsp_ch.run_last   = last_ff;

   // An accepted number always starts a conversion.
   a_accept_converts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_CONVERT)
      else $error("accepted request did not start a conversion");

   // The digit count never runs out while digits are still being walked.
   a_cnt_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TRIM || state_ff == ST_EMIT) |-> cnt_ff != '0)
      else $error("digit count reached zero during emission");

   // Every emitted digit is a valid decimal digit.
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> top_digit <= DigitMax)
      else $error("BCD digit out of range");

   // A sign is never the final character of a run.
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ascii_char == CharMinus) |-> !rsp_ch.run_last)
      else $error("sign character marked as last");

endmodule

// ===== sim/testbench.sv =====
// Testbench for the signed integer to decimal ASCII core: scoreboard, stimulus and stall control.
`timescale 1ns / 1ps

module testbench;
   import sitda_pkg::*;

   localparam int unsigned Radix         = 10;
   localparam int unsigned LongHoldOff   = 300;
   localparam int unsigned DrainCycles   = 60;
   localparam int unsigned RandomBursts  = 60;
   localparam int unsigned RandomGapped  = 120;

   // One expected character of a number's decimal text.
   typedef struct packed {
      logic [CharWidth-1:0] ascii_char;
      logic                 run_last;
   } text_char_type;

   logic clock;
   logic reset;

   sitda_req_if req_ch ();
   sitda_rsp_if rsp_ch ();

   signed_int_to_decimal_ascii_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   text_char_type pending_chars[$];
   int unsigned   error_count     = 0;
   bit            idle_enabled    = 1'b0;
   int unsigned   hold_off_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop: far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("testbench: errors");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   // Queue the characters that the decimal text of one number must produce.
   function automatic void queue_decimal_text(input logic [NumberWidth-1:0] number);
      logic [NumberWidth-1:0] magnitude;
      logic [DigitWidth-1:0]  digit_list [NumDigits];
      int                     digit_count;
      int                     k;
      text_char_type          entry;
      digit_count = 0;
      // Two's complement negation as unsigned keeps the most negative value intact.
      magnitude = number[NumberWidth-1] ? (32'd0 - number) : number;
      do begin
         digit_list[digit_count] = DigitWidth'(magnitude % Radix);
         digit_count++;
         magnitude = magnitude / Radix;
      end while (magnitude != 0 && digit_count < NumDigits);
      if (number[NumberWidth-1]) begin
         entry.ascii_char = CharMinus;
         entry.run_last   = 1'b0;
         pending_chars.push_back(entry);
      end
      for (k = digit_count - 1; k >= 0; k--) begin
         entry.ascii_char = CharZero + CharWidth'(digit_list[k]);
         entry.run_last   = (k == 0);
         pending_chars.push_back(entry);
      end
   endfunction

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Predict on request transactions and check response transactions, both at
   // the same edge in one process so the order between them is fixed.
   always @(posedge clock) begin
      text_char_type got;
      text_char_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            queue_decimal_text(req_ch.number_in);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.ascii_char = rsp_ch.ascii_char;
            got.run_last   = rsp_ch.run_last;
            if (pending_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                         got.ascii_char, got.run_last));
            end else begin
               want = pending_chars.pop_front();
               if (got.ascii_char !== want.ascii_char) begin
                  report_mismatch($sformatf("ascii_char 0x%02h, expected 0x%02h",
                                            got.ascii_char, want.ascii_char));
               end
               if (got.run_last !== want.run_last) begin
                  report_mismatch($sformatf("run_last %0b, expected %0b on char 0x%02h",
                                            got.run_last, want.run_last, want.ascii_char));
               end
            end
         end
      end
   end

   // Response side: random stalls, ready bursts, and the long hold-off on request.
   initial begin
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_cycles != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
         end else if (idle_enabled && $urandom_range(0, 2) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (1 + pick_gap()) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   // Offer one number and hold it until accepted. Valid is dropped only when
   // a gap follows, so back-to-back offers never lower and raise it in one step.
   task automatic send_number(input logic [NumberWidth-1:0] number);
      int unsigned gap;
      gap = idle_enabled ? pick_gap() : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.number_in <= number;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Random number: sometimes fully random or an extreme, else an evenly chosen digit count and a random sign.
   function automatic logic [NumberWidth-1:0] pick_number();
      logic [NumberWidth-1:0] low;
      logic [NumberWidth-1:0] high;
      logic [NumberWidth-1:0] value;
      int unsigned            width_digits;
      int unsigned            roll;
      int unsigned            k;
      roll = $urandom_range(0, 99);
      if (roll < 30) return $urandom();
      if (roll < 34) return 32'h8000_0000;
      if (roll < 38) return 32'h7FFF_FFFF;
      width_digits = $urandom_range(1, NumDigits);
      low = 1;
      for (k = 1; k < width_digits; k++) low = low * Radix;
      high = (width_digits == NumDigits) ? 32'h7FFF_FFFF : low * Radix - 1;
      if (width_digits == 1) low = 0;
      // Land on a decade edge now and then, where the digit count changes.
      case ($urandom_range(0, 5))
         0:       value = low;
         1:       value = high;
         default: value = $urandom_range(high, low);
      endcase
      if ($urandom_range(0, 1) == 1) value = 32'd0 - value;
      return value;
   endfunction

   // Zero, single digits, decade edges, both extremes and alternating bit patterns.
   task automatic test_directed_values();
      logic [NumberWidth-1:0] values [$];
      idle_enabled = 1'b0;
      values = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'hFFFF_FFF6, 32'd99,
                 32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                 32'd999999999, 32'hC465_3601, 32'h5555_5555, 32'hAAAA_AAAA,
                 32'd123456789, 32'hF8A4_32EB, 32'd1000000001, 32'd4294967286,
                 32'd2000000000};
      foreach (values[i]) send_number(values[i]);
   endtask

   // Stall the response side for a long stretch while numbers keep coming.
   task automatic test_output_backpressure();
      idle_enabled    = 1'b0;
      hold_off_cycles = LongHoldOff;
      repeat (8) send_number(pick_number());
   endtask

   task automatic test_random_back_to_back();
      idle_enabled = 1'b0;
      repeat (RandomBursts) send_number(pick_number());
   endtask

   task automatic test_random_with_gaps();
      idle_enabled = 1'b1;
      repeat (RandomGapped) send_number(pick_number());
   endtask

   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.number_in <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_values();
      test_output_backpressure();
      test_random_back_to_back();
      test_random_with_gaps();

      // Release the request side, drain, then allow one more conversion time.
      req_ch.valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (error_count == 0 && pending_chars.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/sitda_pkg.sv
sv/sitda_if.sv
sv/sitda_bcd_conv.sv
sv/signed_int_to_decimal_ascii_core.sv
sim/testbench.sv
